/* src/nls_pkg.sv */
// Package with shared constants and types for the natural log series unit.
package nls_pkg;

	localparam int unsigned TermsDefault = 20;
	localparam int unsigned XW = 32;
	localparam int unsigned QW = 30;
	localparam int unsigned NumW = 33;
	localparam int unsigned DenW = 33;
	localparam int unsigned AccW = 40;
	localparam logic [31:0] ErrValue = 32'hFF00_0000;

	// Side information that travels beside the numeric data of a word.
	typedef struct packed {
		logic neg;
		logic err;
	} nls_tag_t;

endpackage

/* src/nls_div.sv */
// Pipelined restoring divider for t = num * 2^30 / den, one quotient bit a stage.
module nls_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_vld,
	input  logic [nls_pkg::NumW-1:0] num,
	input  logic [nls_pkg::DenW-1:0] den,
	input  nls_pkg::nls_tag_t    in_tag,
	output logic                 out_vld,
	output logic [nls_pkg::QW-1:0] quo,
	output nls_pkg::nls_tag_t    out_tag
);
	import nls_pkg::*;

	localparam int unsigned N = QW;
	localparam int unsigned RW = DenW + 1;

	logic [RW-1:0]   rem_s [0:N];
	logic [DenW-1:0] den_s [0:N];
	logic [N-1:0]    q_s   [0:N];
	nls_tag_t        tag_s [0:N];
	logic [N:0]      vld_s;

	// num < den, so the remainder starts as num and each stage yields one bit.
	assign rem_s[0] = {1'b0, num};
	assign den_s[0] = den;
	assign q_s[0]   = '0;
	assign tag_s[0] = in_tag;
	assign vld_s[0] = in_vld;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [RW:0] sh;
		logic        ge;
		assign sh = {rem_s[k], 1'b0};
		assign ge = sh >= {2'b00, den_s[k]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= ge ? RW'(sh - {2'b00, den_s[k]}) : RW'(sh);
				den_s[k+1] <= den_s[k];
				q_s[k+1]   <= {q_s[k][N-2:0], ge};
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_vld = vld_s[N];
	assign quo     = q_s[N];
	assign out_tag = tag_s[N];

endmodule

/* src/natural_log_series_top.sv */
// Top level of the pipelined natural logarithm unit (atanh series).
// The unit accepts one word per cycle while the output is not stalled and
// returns ln(x) of an unsigned Q16.16 argument as signed Q8.24. It has one
// input stage, 30 divider stages (one quotient bit each), one square stage and
// two stages per series term (multiply by t squared, then divide by the odd
// constant through a reciprocal multiply and correction), plus one output
// stage. A zero argument gives -1.0 with domain_error set. The whole pipeline
// moves only when the output register is empty or being taken, so a stall
// holds every word in place.
module natural_log_series_top #(
	parameter int unsigned TERMS = nls_pkg::TermsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	output logic        ready_in,
	input  logic [31:0] x_value,
	output logic        valid_out,
	input  logic        ready_out,
	output logic signed [31:0] log_value,
	output logic        domain_error
);
	import nls_pkg::*;

	logic adv;
	assign adv = !valid_out || ready_out;
	assign ready_in = adv;

	// Input stage: magnitude of x-1, x+1 and sign.
	logic              v_s1;
	logic [NumW-1:0]   num_s1;
	logic [DenW-1:0]   den_s1;
	nls_tag_t          tag_s1;
	logic [NumW-1:0]   xe;
	assign xe = NumW'(x_value);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= valid_in;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			if (xe >= NumW'(65536)) begin
				num_s1 <= xe - NumW'(65536);
				tag_s1.neg <= 1'b0;
			end else begin
				num_s1 <= NumW'(65536) - xe;
				tag_s1.neg <= 1'b1;
			end
			den_s1 <= xe + DenW'(65536);
			tag_s1.err <= (x_value == '0);
		end
	end

	// Divider: quotient always below 2^30; num < den except for a zero argument, whose divisor is forced to one.
	logic            v_d;
	logic [QW-1:0]   t_d;
	nls_tag_t        tag_d;
	nls_div u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_vld(v_s1), .num(num_s1), .den(tag_s1.err ? DenW'(1) : den_s1),
		.in_tag(tag_s1),
		.out_vld(v_d), .quo(t_d), .out_tag(tag_d)
	);

	// Square stage: t^2 in Q0.30.
	logic           v_sq;
	logic [QW-1:0]  t2_sq, p_sq;
	nls_tag_t       tag_sq;
	logic [2*QW-1:0] sqp;
	assign sqp = {{QW{1'b0}}, t_d} * {{QW{1'b0}}, t_d};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq <= 1'b0;
		end else if (adv) begin
			v_sq <= v_d;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			t2_sq  <= sqp[2*QW-1:QW];
			p_sq   <= t_d;
			tag_sq <= tag_d;
		end
	end

	// Series terms: stage A forms p/(2i+1) and next power; stage B accumulates.
	// A reciprocal scale of 2^32 keeps the estimate within one of the true quotient.
	localparam int unsigned RS = 32;
	logic [QW-1:0] p_c   [0:TERMS];
	logic [QW-1:0] t2_c  [0:TERMS];
	logic [AccW-1:0] acc_c [0:TERMS];
	nls_tag_t      tag_c [0:TERMS];
	logic [TERMS:0] v_c;
	assign p_c[0] = p_sq;
	assign t2_c[0] = t2_sq;
	assign acc_c[0] = '0;
	assign tag_c[0] = tag_sq;
	assign v_c[0] = v_sq;

	for (genvar i = 0; i < TERMS; i++) begin : g_term
		localparam int unsigned D = 2 * i + 1;
		localparam longint unsigned RECIP = ((64'd1 << RS) + D - 1) / D;
		logic            va;
		logic [QW-1:0]   pa, t2a, pn;
		logic [AccW-1:0] acca;
		nls_tag_t        taga;
		logic [QW+RS:0] prod;
		logic [QW+RS:0] prod_a;
		logic [QW-1:0]  qe, qc;
		logic [2*QW-1:0] pm;
		// Power update and reciprocal product, registered separately.
		assign pm = {{QW{1'b0}}, p_c[i]} * {{QW{1'b0}}, t2_c[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				va <= 1'b0;
				v_c[i+1] <= 1'b0;
			end else if (adv) begin
				va <= v_c[i];
				v_c[i+1] <= va;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				pa <= p_c[i];
				pn <= pm[2*QW-1:QW];
				t2a <= t2_c[i];
				acca <= acc_c[i];
				taga <= tag_c[i];
				prod_a <= (QW+RS+1)'(p_c[i]) * (QW+RS+1)'(RECIP);
			end
		end
		// Ceiling reciprocal may overshoot by one: correct with one compare.
		assign prod = prod_a;
		assign qe = QW'(prod >> RS);
		assign qc = ((QW+8)'(qe) * (QW+8)'(D) > (QW+8)'(pa)) ? qe - QW'(1) : qe;
		always_ff @(posedge clk) begin
			if (adv) begin
				p_c[i+1]   <= pn;
				t2_c[i+1]  <= t2a;
				acc_c[i+1] <= acca + AccW'(qc);
				tag_c[i+1] <= taga;
			end
		end
	end

	// Output stage: scale, apply sign, error value.
	logic [AccW-1:0] r;
	assign r = acc_c[TERMS] >> 5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (adv) begin
			valid_out <= v_c[TERMS];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			domain_error <= tag_c[TERMS].err;
			if (tag_c[TERMS].err) begin
				log_value <= ErrValue;
			end else if (tag_c[TERMS].neg) begin
				log_value <= 32'd0 - r[31:0];
			end else begin
				log_value <= r[31:0];
			end
		end
	end

	// Stalled output word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && !ready_out |=> valid_out && $stable(log_value))
		else $error("output word changed while stalled");
	// Error words always carry the error value.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && domain_error |-> log_value == ErrValue)
		else $error("error word without error value");
	// Input ready follows the output register state.
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && !ready_out |-> !ready_in)
		else $error("input taken while output stalled");

endmodule

/* dv/natural_log_series_checker.sv */
// Checker that predicts and compares every result word of the natural log unit.
module natural_log_series_checker #(
	parameter int unsigned TERMS = nls_pkg::TermsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_in,
	input  logic               ready_in,
	input  logic [31:0]        x_value,
	input  logic               valid_out,
	input  logic               ready_out,
	input  logic signed [31:0] log_value,
	input  logic               domain_error,
	output int                 fail_count,
	output int                 pending_count,
	output int                 result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] value;
		logic        err;
	} log_word_t;

	log_word_t expected_logs[$];

	// Truncated atanh series on the magnitude of t, sign applied at the end.
	function automatic log_word_t predict_log(logic [31:0] x);
		log_word_t w;
		logic [63:0] num, den, tmag, tsq, pw, acc, r;
		logic neg;
		w.err = 1'b0;
		if (x == 32'd0) begin
			w.value = nls_pkg::ErrValue;
			w.err = 1'b1;
			return w;
		end
		neg = (x < 32'h0001_0000);
		num = neg ? (64'h1_0000 - x) : (64'(x) - 64'h1_0000);
		den = 64'(x) + 64'h1_0000;
		tmag = (num << 30) / den;
		if (tmag >= 64'h4000_0000)
			tmag = 64'h3FFF_FFFF;
		tsq = (tmag * tmag) >> 30;
		pw = tmag;
		acc = 0;
		for (int i = 0; i < TERMS; i++) begin
			acc += pw / 64'(2 * i + 1);
			pw = (pw * tsq) >> 30;
		end
		r = acc >> 5;
		if (neg) begin
			if (r > 64'h8000_0000)
				r = 64'h8000_0000;
			w.value = 32'(64'd0 - r);
		end else begin
			if (r > 64'h7FFF_FFFF)
				r = 64'h7FFF_FFFF;
			w.value = r[31:0];
		end
		return w;
	endfunction

	assign pending_count = expected_logs.size();

	// Queue a prediction per accepted word and compare each result word in order.
	always @(posedge clk or negedge arst_n) begin
		log_word_t want;
		if (!arst_n) begin
			fail_count <= 0;
			result_count <= 0;
			expected_logs.delete();
		end else begin
			if (valid_in && ready_in)
				expected_logs.push_back(predict_log(x_value));
			if (valid_out && ready_out) begin
				result_count <= result_count + 1;
				if (expected_logs.size() == 0) begin
					if (fail_count < 10)
						$display("ERROR: unexpected result word log=%h err=%b",
							log_value, domain_error);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_logs.pop_front();
					if (want.value !== log_value || want.err !== domain_error) begin
						if (fail_count < 10)
							$display("ERROR: log exp %h/%b got %h/%b", want.value,
								want.err, log_value, domain_error);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

/* dv/tb.sv */
// Testbench top: drives argument words with bursts and gaps, stalls the output, reports.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Latency = 33 + 2 * nls_pkg::TermsDefault;
	localparam int CycleLimit = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic valid_in = 1'b0;
	logic ready_in;
	logic [31:0] x_value = 32'd0;
	logic valid_out;
	logic ready_out = 1'b0;
	logic signed [31:0] log_value;
	logic domain_error;
	int fail_count, pending_count, result_count;
	int cycle_count = 0;
	int sent_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	natural_log_series_top dut (.*);

	natural_log_series_checker checker_i (.*);

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver stalls in runs: phases of always ready and phases of random stalls.
	always @(posedge clk) begin
		if (cycle_count % 400 < 100)
			ready_out <= 1'b1;
		else if (cycle_count % 400 < 250)
			ready_out <= ($urandom_range(0, 3) != 0);
		else
			ready_out <= ($urandom_range(0, 2) == 0);
	end

	// Random argument with mixed ranges so every bit toggles and one stays common.
	function automatic logic [31:0] random_arg();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h0001_0000 + $urandom_range(0, 255) - 128;
			2: return $urandom_range(1, 32'h0001_0000);
			3: return 32'h0001_0000 << $urandom_range(0, 15);
			4: return $urandom_range(0, 3);
			default: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
		endcase
	endfunction

	// Present one word and hold it until accepted.
	task automatic send_word(input logic [31:0] x);
		valid_in <= 1'b1;
		x_value <= x;
		do @(posedge clk); while (!ready_in);
		sent_count++;
	endtask

	task automatic pause_valid(input int n);
		valid_in <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	logic [31:0] directed_args[] = '{32'd0, 32'h0001_0000, 32'd1, 32'hFFFF_FFFF,
		32'h0000_FFFF, 32'h0001_0001, 32'h0002_0000, 32'h0000_8000, 32'h8000_0000,
		32'h7FFF_FFFF, 32'h0002_B7E1, 32'h0000_5E2D, 32'd2, 32'hFFFF_0000,
		32'h5555_5555, 32'hAAAA_AAAA, 32'd0};

	initial begin
		int burst;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed extremes back to back: zero, one, edges of the range.
		foreach (directed_args[i])
			send_word(directed_args[i]);
		pause_valid(1);
		// Let the pipeline drain fully once before the random part.
		while (pending_count != 0)
			@(posedge clk);
		while (sent_count < 550) begin
			burst = $urandom_range(1, 40);
			repeat (burst)
				send_word(random_arg());
			if ($urandom_range(0, 2) != 0)
				pause_valid($urandom_range(1, 12));
		end
		valid_in <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (Latency + 10) @(posedge clk);
		$display("Ran %0d argument words, %0d results, incl. zero, one and range ends.",
			sent_count, result_count);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
